/* src/mcpip_pkg.sv */
package mcpip_pkg;

    localparam int MAX_VERTICES_DFLT = 1024;
    localparam int COORD_BITS_DFLT   = 32;
    localparam int FIELD_W           = 32;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]                action;
        logic signed [FIELD_W-1:0] coord_x;
        logic signed [FIELD_W-1:0] coord_y;
        logic                      closes_contour;
    } in_item_t;

    typedef struct packed {
        logic inside_res;
        logic on_boundary;
        logic overflowed;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic rd_final;
        logic q_start;
        logic res_load;
        logic overflow;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic busy;
    } dp_stat_t;

endpackage

/* src/mcpip_ram.sv */
module mcpip_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/mcpip_ctrl.sv */
module mcpip_ctrl
    import mcpip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DFLT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  logic [1:0]                      action,
    output logic                            item_stall,
    output logic                            result_valid,
    input  logic                            result_stall,
    output dp_cmd_t                         cmd,
    input  dp_stat_t                        stat,
    output logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
    output logic [$clog2(MAX_VERTICES)-1:0] rd_addr
);

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] addr_reg, addr_next;
    logic             ovf_reg, ovf_next;
    logic             res_valid_reg, res_valid_next;
    logic             accept;
    logic             scan_last;
    logic             room;

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign accept       = item_valid && (state_reg == ST_IDLE);
    assign scan_last    = (addr_reg == count_reg - CNT_W'(1));
    assign room         = (count_reg < CNT_W'(MAX_VERTICES));
    assign wr_addr      = count_reg[ADDR_W-1:0];
    assign rd_addr      = addr_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        ovf_next       = ovf_reg;
        res_valid_next = res_valid_reg;
        cmd            = '0;
        cmd.overflow   = ovf_reg;

        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        ACT_APPEND:
                        begin
                            if (room)
                            begin
                                cmd.wr_en  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        ACT_QUERY:
                        begin
                            cmd.q_start = 1'b1;
                            addr_next   = '0;
                            state_next  = (count_reg == '0) ? ST_FINISH : ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_final = scan_last;
                addr_next    = addr_reg + CNT_W'(1);
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    cmd.res_load   = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            addr_reg      <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

/* src/mcpip_dp.sv */
module mcpip_dp
    import mcpip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DFLT,
    parameter int COORD_BITS   = COORD_BITS_DFLT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  in_item_t                        item,
    input  dp_cmd_t                         cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
    input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
    output dp_stat_t                        stat,
    output out_item_t                       result
);

    localparam int CB    = COORD_BITS;
    localparam int DW    = COORD_BITS + 1;
    localparam int PW    = 2 * DW;
    localparam int RAM_W = 2 * COORD_BITS + 1;

    // vertex memory: {x, y, end mark}
    logic [RAM_W-1:0]     ram_wdata, ram_rdata;
    logic signed [CB-1:0] vx, vy;
    logic                 vmark, vlast;

    logic                 rdv_reg, rdfin_reg;
    logic signed [CB-1:0] qx_reg, qy_reg;

    // edge former
    logic signed [CB-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic                 pend_reg, nfirst_reg;

    // edge stage
    logic signed [CB-1:0] ei_x_next, ei_y_next, ej_x_next, ej_y_next;
    logic signed [CB-1:0] ei_x_reg, ei_y_reg, ej_x_reg, ej_y_reg;
    logic                 e_v_next, e_end_next, e_v_reg, e_end_reg;

    // difference stage
    logic signed [DW-1:0] s1_a_reg, s1_dy_reg, s1_b_reg, s1_c_reg;
    logic                 s1_span_reg, s1_box_reg, s1_dypos_reg, s1_end_reg, s1_v_reg;
    logic                 span, box;

    // product stage
    logic signed [PW-1:0] p1_next, p2_next, p1_reg, p2_reg;
    logic                 s2_span_reg, s2_box_reg, s2_dypos_reg, s2_end_reg, s2_v_reg;

    // accumulators
    logic                 lt, eq, gt, cr_now, ed_now;
    logic                 odd_reg, cross_any_reg, edge_any_reg;

    assign ram_wdata = {item.coord_x[CB-1:0], item.coord_y[CB-1:0], item.closes_contour};

    mcpip_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_VERTICES)
    ) u_vram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    assign vx    = ram_rdata[RAM_W-1 -: CB];
    assign vy    = ram_rdata[CB -: CB];
    assign vmark = ram_rdata[0];
    assign vlast = vmark || rdfin_reg;

    assign stat.busy = rdv_reg || pend_reg || e_v_reg || s1_v_reg || s2_v_reg;

    // a contour's first vertex forms no edge, so the previous contour's closing
    // edge goes out in its slot; the final one is flushed after the scan
    always_comb
    begin
        ei_x_next  = first_x_reg;
        ei_y_next  = first_y_reg;
        ej_x_next  = prev_x_reg;
        ej_y_next  = prev_y_reg;
        e_end_next = 1'b1;
        e_v_next   = 1'b0;
        if (rdv_reg)
        begin
            if (nfirst_reg)
            begin
                e_v_next = pend_reg;
            end
            else
            begin
                ei_x_next  = vx;
                ei_y_next  = vy;
                e_end_next = 1'b0;
                e_v_next   = 1'b1;
            end
        end
        else
        begin
            e_v_next = pend_reg;
        end
    end

    assign span = ((ei_y_reg <= qy_reg) && (qy_reg < ej_y_reg))
               || ((ej_y_reg <= qy_reg) && (qy_reg < ei_y_reg));
    assign box  = ((qx_reg >= ei_x_reg) || (qx_reg >= ej_x_reg))
               && ((qx_reg <= ei_x_reg) || (qx_reg <= ej_x_reg))
               && ((qy_reg >= ei_y_reg) || (qy_reg >= ej_y_reg))
               && ((qy_reg <= ei_y_reg) || (qy_reg <= ej_y_reg));

    assign p1_next = s1_a_reg * s1_dy_reg;
    assign p2_next = s1_b_reg * s1_c_reg;

    assign lt     = (p1_reg < p2_reg);
    assign eq     = (p1_reg == p2_reg);
    assign gt     = !lt && !eq;
    assign cr_now = s2_span_reg && (s2_dypos_reg ? lt : gt);
    assign ed_now = s2_box_reg && eq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdv_reg       <= 1'b0;
            rdfin_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            nfirst_reg    <= 1'b1;
            e_v_reg       <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            odd_reg       <= 1'b0;
            cross_any_reg <= 1'b0;
            edge_any_reg  <= 1'b0;
        end
        else
        begin
            rdv_reg   <= cmd.rd_en;
            rdfin_reg <= cmd.rd_final;
            e_v_reg   <= e_v_next;
            s1_v_reg  <= e_v_reg;
            s2_v_reg  <= s1_v_reg;

            if (cmd.q_start)
            begin
                pend_reg   <= 1'b0;
                nfirst_reg <= 1'b1;
            end
            else if (rdv_reg)
            begin
                pend_reg   <= vlast;
                nfirst_reg <= vlast;
            end
            else
            begin
                pend_reg <= 1'b0;
            end

            if (cmd.q_start)
            begin
                odd_reg       <= 1'b0;
                cross_any_reg <= 1'b0;
                edge_any_reg  <= 1'b0;
            end
            else if (s2_v_reg)
            begin
                if (s2_end_reg)
                begin
                    cross_any_reg <= cross_any_reg || (odd_reg ^ cr_now);
                    odd_reg       <= 1'b0;
                end
                else
                begin
                    odd_reg <= odd_reg ^ cr_now;
                end
                edge_any_reg <= edge_any_reg || ed_now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_start)
        begin
            qx_reg <= item.coord_x[CB-1:0];
            qy_reg <= item.coord_y[CB-1:0];
        end

        if (rdv_reg)
        begin
            prev_x_reg <= vx;
            prev_y_reg <= vy;
            if (nfirst_reg)
            begin
                first_x_reg <= vx;
                first_y_reg <= vy;
            end
        end

        ei_x_reg  <= ei_x_next;
        ei_y_reg  <= ei_y_next;
        ej_x_reg  <= ej_x_next;
        ej_y_reg  <= ej_y_next;
        e_end_reg <= e_end_next;

        s1_a_reg     <= {qx_reg[CB-1], qx_reg} - {ei_x_reg[CB-1], ei_x_reg};
        s1_dy_reg    <= {ej_y_reg[CB-1], ej_y_reg} - {ei_y_reg[CB-1], ei_y_reg};
        s1_b_reg     <= {ej_x_reg[CB-1], ej_x_reg} - {ei_x_reg[CB-1], ei_x_reg};
        s1_c_reg     <= {qy_reg[CB-1], qy_reg} - {ei_y_reg[CB-1], ei_y_reg};
        s1_span_reg  <= span;
        s1_box_reg   <= box;
        s1_dypos_reg <= (ej_y_reg > ei_y_reg);
        s1_end_reg   <= e_end_reg;

        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        s2_span_reg  <= s1_span_reg;
        s2_box_reg   <= s1_box_reg;
        s2_dypos_reg <= s1_dypos_reg;
        s2_end_reg   <= s1_end_reg;

        if (cmd.res_load)
        begin
            result.inside_res  <= cross_any_reg || edge_any_reg;
            result.on_boundary <= !cross_any_reg && edge_any_reg;
            result.overflowed  <= cmd.overflow;
        end
    end

endmodule

/* src/multi_contour_point_in_polygon.sv */
// Even-odd point-in-polygon test over a table of closed contours held in one
// vertex RAM. Clear and append beats are taken without leaving the idle state,
// so they can arrive back to back. A query beat walks the stored vertices one
// RAM entry per cycle through a single edge unit (difference, multiply and
// compare stages); item_stall stays high until its result is loaded. The
// result sits in an output register, so a new beat is taken while it waits.
// A point on any edge counts as inside and is also reported in on_boundary
// when no contour's crossing count is odd. overflowed is sticky until clear.
module multi_contour_point_in_polygon
    import mcpip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DFLT,
    parameter int COORD_BITS   = COORD_BITS_DFLT
) (
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  item,
    input  logic      item_valid,
    output logic      item_stall,
    output out_item_t result,
    output logic      result_valid,
    input  logic      result_stall
);

    localparam int ADDR_W = $clog2(MAX_VERTICES);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    mcpip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .action       (item.action),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .stat         (stat),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr)
    );

    mcpip_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .cmd     (cmd),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .stat    (stat),
        .result  (result)
    );

endmodule

/* bench/multi_contour_point_in_polygon_tb.sv */
`timescale 1ns / 100ps

module multi_contour_point_in_polygon_tb
    import mcpip_pkg::*;
();

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         TABLE_DEPTH = MAX_VERTICES_DFLT;
    localparam int         PRINT_CAP   = 40;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [31:0]  coord_t;

    // even-odd containment predictor plus the queue of answers still owed
    class pip_scoreboard;
        longint    vx[TABLE_DEPTH];
        longint    vy[TABLE_DEPTH];
        bit        vend[TABLE_DEPTH];
        int        stored;
        bit        dropped;
        out_item_t answers[$];
        int        errors;

        function new();
            stored  = 0;
            dropped = 0;
            errors  = 0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        // strict crossing of the rightward ray, half-open in y
        function bit crosses(longint px, py, ax, ay, bx, by);
            wide_t t1, t2, t3, t4, lhs, rhs;
            longint dy;
            if (!((ay <= py && py < by) || (by <= py && py < ay)))
                return 1'b0;
            dy  = by - ay;
            t1  = px - ax;
            t2  = dy;
            t3  = bx - ax;
            t4  = py - ay;
            lhs = t1 * t2;
            rhs = t3 * t4;
            return (dy > 0) ? (lhs < rhs) : (lhs > rhs);
        endfunction

        function bit on_edge(longint px, py, ax, ay, bx, by);
            wide_t t1, t2, t3, t4;
            longint lox, hix, loy, hiy;
            lox = (ax < bx) ? ax : bx;
            hix = (ax < bx) ? bx : ax;
            loy = (ay < by) ? ay : by;
            hiy = (ay < by) ? by : ay;
            if (px < lox || px > hix || py < loy || py > hiy)
                return 1'b0;
            t1 = bx - ax;
            t2 = py - ay;
            t3 = by - ay;
            t4 = px - ax;
            return (t1 * t2) == (t3 * t4);
        endfunction

        function out_item_t locate(longint px, longint py);
            out_item_t r;
            int first, last, prev;
            bit odd, cross_any, edge_any;
            cross_any = 1'b0;
            edge_any  = 1'b0;
            first     = 0;
            while (first < stored)
            begin
                last = first;
                while (last + 1 < stored && !vend[last])
                    last++;
                odd  = 1'b0;
                prev = last;
                for (int k = first; k <= last; k++)
                begin
                    if (crosses(px, py, vx[k], vy[k], vx[prev], vy[prev]))
                        odd = !odd;
                    if (on_edge(px, py, vx[k], vy[k], vx[prev], vy[prev]))
                        edge_any = 1'b1;
                    prev = k;
                end
                if (odd)
                    cross_any = 1'b1;
                first = last + 1;
            end
            r.inside_res  = cross_any || edge_any;
            r.on_boundary = !cross_any && edge_any;
            r.overflowed  = dropped;
            return r;
        endfunction

        task note_beat(in_item_t beat);
            case (beat.action)
                ACT_CLEAR:
                begin
                    stored  = 0;
                    dropped = 1'b0;
                end
                ACT_APPEND:
                begin
                    if (stored < TABLE_DEPTH)
                    begin
                        vx[stored]   = beat.coord_x;
                        vy[stored]   = beat.coord_y;
                        vend[stored] = beat.closes_contour;
                        stored++;
                    end
                    else
                        dropped = 1'b1;
                end
                ACT_QUERY:
                    answers.insert(answers.size(), locate(beat.coord_x, beat.coord_y));
                default:
                    ;
            endcase
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (answers.size() == 0)
            begin
                report("result beat with no query outstanding");
                return;
            end
            want = answers.pop_front();
            if (got.inside_res !== want.inside_res)
                report($sformatf("inside_res %b, expected %b",
                                 got.inside_res, want.inside_res));
            if (got.on_boundary !== want.on_boundary)
                report($sformatf("on_boundary %b, expected %b",
                                 got.on_boundary, want.on_boundary));
            if (got.overflowed !== want.overflowed)
                report($sformatf("overflowed %b, expected %b",
                                 got.overflowed, want.overflowed));
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    in_item_t  item;
    logic      item_valid;
    logic      item_stall;
    out_item_t result;
    logic      result_valid;
    logic      result_stall = 1'b0;

    pip_scoreboard sb;
    int            idle_odds = 0;
    int            hold_left = 0;
    int unsigned   cycles = 0;
    int            sent = 0;
    int            loaded = 0;
    coord_t        placed_x[$];
    coord_t        placed_y[$];

    multi_contour_point_in_polygon uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side back-pressure in bursts
    always @(posedge clk)
    begin
        if (hold_left > 1)
            hold_left <= hold_left - 1;
        else if (hold_left == 1)
        begin
            hold_left    <= 0;
            result_stall <= 1'b0;
        end
        else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds)
        begin
            result_stall <= 1'b1;
            hold_left    <= $urandom_range(1, 9);
        end
    end

    // result checked before the input of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_result(result);
            if (item_valid && !item_stall)
                sb.note_beat(item);
        end
    end

    function automatic in_item_t make_beat(logic [1:0] act, coord_t x, coord_t y,
                                           logic closes);
        in_item_t b;
        b.action         = act;
        b.coord_x        = x;
        b.coord_y        = y;
        b.closes_contour = closes;
        return b;
    endfunction

    // called right after a rising edge; returns at the accepting edge or after a gap
    task automatic send_beat(in_item_t beat);
        int gap;
        item       <= beat;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (beat.action != ACT_UNUSED)
            sent++;
        if (beat.action == ACT_APPEND)
        begin
            placed_x.insert(placed_x.size(), beat.coord_x);
            placed_y.insert(placed_y.size(), beat.coord_y);
            loaded++;
        end
        else if (beat.action == ACT_CLEAR)
        begin
            placed_x.delete();
            placed_y.delete();
            loaded = 0;
        end
        if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds)
        begin
            gap = $urandom_range(1, 9);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // small grids make vertex and edge hits common
    function automatic coord_t pick_coord(int mode);
        int v;
        if (mode < 7)
        begin
            v = (int'($urandom_range(0, 16)) - 8) * 256;
            if ($urandom_range(0, 3) == 0)
                v = v + int'($urandom_range(0, 511)) - 256;
            return v;
        end
        if (mode == 7)
            return int'($urandom_range(0, 200)) - 100;
        if (mode == 8)
            return $urandom();
        case ($urandom_range(0, 4))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 0;
            3: return -1;
            default: return $urandom();
        endcase
    endfunction

    function automatic coord_t pick_query(int mode, bit want_y);
        int     sel, n, k;
        longint s;
        sel = $urandom_range(0, 9);
        n   = placed_x.size();
        k   = (n > 0) ? $urandom_range(0, n - 1) : 0;
        if (n > 0 && sel < 3)
            return want_y ? placed_y[k] : placed_x[k];
        if (n > 1 && sel < 5)
        begin
            if (k == n - 1)
                k = n - 2;
            s = want_y ? longint'(placed_y[k]) + longint'(placed_y[k + 1])
                       : longint'(placed_x[k]) + longint'(placed_x[k + 1]);
            return coord_t'(s >>> 1);
        end
        if (sel < 9)
            return pick_coord(mode);
        return $urandom();
    endfunction

    task automatic query_at(coord_t x, coord_t y);
        send_beat(make_beat(ACT_QUERY, x, y, 1'b0));
    endtask

    task automatic vertex_at(coord_t x, coord_t y, logic closes);
        send_beat(make_beat(ACT_APPEND, x, y, closes));
    endtask

    task automatic run_directed();
        query_at(0, 0);                       // empty table
        vertex_at(0, 0, 1'b0);
        vertex_at(1024, 0, 1'b0);
        vertex_at(1024, 1024, 1'b0);
        vertex_at(0, 1024, 1'b1);
        query_at(512, 512);
        query_at(2048, 512);
        query_at(1024, 512);                  // on a vertical edge
        query_at(512, 0);                     // on a horizontal edge
        query_at(0, 0);                       // on a vertex
        query_at(-1, 512);
        vertex_at(3000, 3000, 1'b1);          // single-vertex contour
        query_at(3000, 3000);
        query_at(3001, 3000);
        // unterminated triangle at the coordinate extremes
        vertex_at(32'sh8000_0000, 32'sh8000_0000, 1'b0);
        vertex_at(32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
        vertex_at(0, 32'sh7fff_ffff, 1'b0);
        query_at(32'sh8000_0000, 32'sh8000_0000);
        query_at(32'sh7fff_ffff, 32'sh7fff_ffff);
        query_at(0, -1000000);
        send_beat(make_beat(ACT_UNUSED, -1, -1, 1'b1));
        send_beat(make_beat(ACT_CLEAR, -1, -1, 1'b1));
        query_at(512, 512);
    endtask

    task automatic random_phase();
        int     contours, pts, mode, queries;
        logic   closes;
        coord_t x, y;
        if (loaded > 200 || $urandom_range(0, 3) != 0)
            send_beat(make_beat(ACT_CLEAR, $urandom(), $urandom(),
                                1'($urandom_range(0, 1))));
        mode     = $urandom_range(0, 9);
        contours = $urandom_range(1, 3);
        repeat (contours)
        begin
            pts = $urandom_range(1, 7);
            for (int i = 0; i < pts; i++)
            begin
                if (i == pts - 1)
                    closes = ($urandom_range(0, 5) != 0);
                else
                    closes = ($urandom_range(0, 15) == 0);
                x = pick_coord(mode);
                y = pick_coord(mode);
                vertex_at(x, y, closes);
            end
        end
        queries = $urandom_range(2, 8);
        repeat (queries)
        begin
            if ($urandom_range(0, 19) == 0)
                send_beat(make_beat(ACT_UNUSED, $urandom(), $urandom(),
                                    1'($urandom_range(0, 1))));
            x = pick_query(mode, 1'b0);
            y = pick_query(mode, 1'b1);
            query_at(x, y);
        end
    endtask

    function automatic int pick_idle();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    initial
    begin
        sb         = new();
        rst_n      = 1'b0;
        item       = '0;
        item_valid = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_odds = 30;
        run_directed();

        while (sent < 440)
        begin
            idle_odds = pick_idle();
            random_phase();
        end

        // closing stretch at full rate on both sides
        idle_odds = 0;
        repeat (8)
            random_phase();

        item_valid <= 1'b0;
        while (sb.answers.size() != 0)
            @(posedge clk);
        repeat (1100) @(posedge clk);

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
src/mcpip_pkg.sv
src/mcpip_ram.sv
src/mcpip_ctrl.sv
src/mcpip_dp.sv
src/multi_contour_point_in_polygon.sv
bench/multi_contour_point_in_polygon_tb.sv
